### src/cmvg_pkg.sv
// ----------------------------------------------------------------------------
// cmvg_pkg
// shared types and constants of the capsule mesh vertex generator
// ----------------------------------------------------------------------------
package cmvg_pkg;

    localparam int CNT_W     = 9;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam int MAX_STACKS             = 256;
    localparam int MAX_SLICES             = 256;
    localparam int DEF_SINE_ROM_DEPTH     = 1024;
    localparam int QUEUE_DEPTH            = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPHERE_RADIUS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BODY_LENGTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_COUNT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_COUNT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LATITUDE_STEP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LONGITUDE_STEP = 3'd5;

    // reset values
    localparam logic [15:0]      RST_SPHERE_RADIUS  = 16'd256;
    localparam logic [15:0]      RST_BODY_LENGTH    = 16'd512;
    localparam logic [CNT_W-1:0] RST_STACK_COUNT    = 9'd16;
    localparam logic [CNT_W-1:0] RST_SLICE_COUNT    = 9'd16;
    localparam logic [15:0]      RST_LATITUDE_STEP  = 16'd2048;
    localparam logic [15:0]      RST_LONGITUDE_STEP = 16'd4096;

    typedef struct packed {
        logic [15:0]      sphere_radius;
        logic [15:0]      body_length;
        logic [CNT_W-1:0] stack_count;
        logic [CNT_W-1:0] slice_count;
        logic [15:0]      latitude_step;
        logic [15:0]      longitude_step;
    } t_cfg;

    // one classified vertex request
    typedef struct packed {
        logic [CNT_W-1:0] lat;
        logic [CNT_W-1:0] slice;
        logic [CNT_W-1:0] strip;
        logic             neg_off;
        logic             strip_end;
        logic             mesh_end;
    } t_job;

    typedef struct packed {
        logic                mesh_end;
        logic                strip_end;
        logic [CNT_W-1:0]    strip_number;
        logic signed [15:0]  normal_z;
        logic signed [15:0]  normal_y;
        logic signed [15:0]  normal_x;
        logic signed [17:0]  pos_z;
        logic signed [16:0]  pos_y;
        logic signed [16:0]  pos_x;
    } t_vertex;

endpackage

### src/cmvg_sine_rom.sv
// ----------------------------------------------------------------------------
// cmvg_sine_rom
// single-port sine table in Q1.15, contents built at elaboration, registered read
// ----------------------------------------------------------------------------
module cmvg_sine_rom #(
    parameter int DEPTH = cmvg_pkg::DEF_SINE_ROM_DEPTH
) (
    input  logic                       i_clk,
    input  logic [$clog2(DEPTH)-1:0]   i_addr,
    output logic signed [15:0]         o_data
);
    function automatic logic signed [15:0] sine_entry(input int idx);
        logic [63:0] a;
        logic [63:0] f;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] v;
        logic [1:0]  quad;
        a    = ((64'(idx) * 64'd65536) / DEPTH) & 64'hFFFF;
        quad = a[15:14];
        f    = a & 64'h3FFF;
        x    = quad[0] ? (64'd16384 - f) : f;
        x2   = (x * x) >> 14;
        t    = 64'd21024 - ((64'd2320 * x2) >> 14);
        t    = 64'd51472 - ((t * x2) >> 14);
        v    = (t * x) >> 14;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return quad[1] ? $signed(-v[15:0]) : $signed(v[15:0]);
    endfunction

    logic signed [15:0] w_table [DEPTH];
    logic signed [15:0] r_data;

    for (genvar g = 0; g < DEPTH; g++) begin : g_entry
        localparam logic signed [15:0] EntryVal = sine_entry(g);
        assign w_table[g] = EntryVal;
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_table[i_addr];
    end

    assign o_data = r_data;

endmodule

### src/cmvg_queue.sv
// ----------------------------------------------------------------------------
// cmvg_queue
// short request queue between the front and back ends
// ----------------------------------------------------------------------------
module cmvg_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cmvg_pkg::t_job  i_wdata,
    output logic            o_full,
    input  logic            i_pop,
    output cmvg_pkg::t_job  o_rdata,
    output logic            o_empty
);
    import cmvg_pkg::*;

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

    t_job            r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_full  = (r_count == FullCnt);
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];

endmodule

### src/cmvg_front.sv
// ----------------------------------------------------------------------------
// cmvg_front
// accepts input words, walks strips, slices and vertex pairs, classifies vertices
// ----------------------------------------------------------------------------
module cmvg_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cmvg_pkg::t_cfg  i_cfg,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic            i_restart,
    input  logic            i_full,
    output logic            o_push,
    output cmvg_pkg::t_job  o_job
);
    import cmvg_pkg::*;

    logic [CNT_W-1:0] r_strip;
    logic [CNT_W-1:0] r_slice;
    logic             r_pair;

    logic [CNT_W-1:0] w_stacks;
    logic [CNT_W-1:0] w_slices;
    logic [CNT_W-1:0] w_half;
    logic [CNT_W-1:0] w_strip;
    logic [CNT_W-1:0] w_slice;
    logic             w_pair;
    logic [CNT_W-1:0] w_lat;
    logic             w_neg;
    logic             w_s_end;
    logic             w_m_end;
    logic             w_accept;

    always_comb begin
        priority if (i_cfg.stack_count < CNT_W'(2)) begin
            w_stacks = CNT_W'(2);
        end else if (int'(i_cfg.stack_count) > MAX_STACKS) begin
            w_stacks = CNT_W'(MAX_STACKS);
        end else begin
            w_stacks = i_cfg.stack_count;
        end
        priority if (i_cfg.slice_count < CNT_W'(3)) begin
            w_slices = CNT_W'(3);
        end else if (int'(i_cfg.slice_count) > MAX_SLICES) begin
            w_slices = CNT_W'(MAX_SLICES);
        end else begin
            w_slices = i_cfg.slice_count;
        end
    end

    assign w_half  = w_stacks >> 1;
    assign w_strip = i_restart ? '0 : r_strip;
    assign w_slice = i_restart ? '0 : r_slice;
    assign w_pair  = i_restart ? 1'b0 : r_pair;

    always_comb begin
        priority if (w_strip < w_half) begin
            w_lat = w_strip + CNT_W'(w_pair);
            w_neg = 1'b0;
        end else if (w_strip == w_half) begin
            w_lat = w_half;
            w_neg = w_pair;
        end else begin
            w_lat = w_strip - 1'b1 + CNT_W'(w_pair);
            w_neg = 1'b1;
        end
    end

    assign w_s_end  = w_pair && (w_slice >= w_slices);
    assign w_m_end  = w_s_end && (w_strip >= w_stacks);
    assign w_accept = i_s_tvalid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip <= '0;
            r_slice <= '0;
            r_pair  <= 1'b0;
        end else if (w_accept) begin
            r_strip <= w_strip;
            r_slice <= w_slice;
            r_pair  <= !w_pair;
            if (w_pair) begin
                if (w_s_end) begin
                    r_slice <= '0;
                    r_strip <= w_m_end ? '0 : w_strip + 1'b1;
                end else begin
                    r_slice <= w_slice + 1'b1;
                end
            end
        end
    end

    assign o_s_tready      = !i_full;
    assign o_push          = w_accept;
    assign o_job.lat       = w_lat;
    assign o_job.slice     = w_slice;
    assign o_job.strip     = w_strip;
    assign o_job.neg_off   = w_neg;
    assign o_job.strip_end = w_s_end;
    assign o_job.mesh_end  = w_m_end;

endmodule

### src/cmvg_back.sv
// ----------------------------------------------------------------------------
// cmvg_back
// phase, sine lookup, multiply and rounding sequencer with output register
// ----------------------------------------------------------------------------
module cmvg_back #(
    parameter int SINE_ROM_DEPTH = cmvg_pkg::DEF_SINE_ROM_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cmvg_pkg::t_cfg     i_cfg,
    input  logic               i_empty,
    input  cmvg_pkg::t_job     i_job,
    output logic               o_pop,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output cmvg_pkg::t_vertex  o_vertex
);
    import cmvg_pkg::*;

    localparam int RomAw = $clog2(SINE_ROM_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_RDW,
        ST_MUL1,
        ST_MUL2,
        ST_OUT
    } t_state;

    function automatic logic signed [49:0] round_shr(input logic signed [49:0] p,
                                                     input int sh);
        logic signed [49:0] h;
        logic signed [49:0] n;
        h = 50'sd1 <<< (sh - 1);
        n = $signed({49'd0, p[49]});
        return (p + h - n) >>> sh;
    endfunction

    t_state              r_state;
    t_job                r_job;
    logic [15:0]         r_lat_phase;
    logic [15:0]         r_lon_phase;
    logic signed [15:0]  r_sl;
    logic signed [15:0]  r_cl;
    logic signed [15:0]  r_sn;
    logic signed [15:0]  r_cn;
    logic signed [31:0]  r_p_ss;
    logic signed [31:0]  r_p_sc;
    logic signed [32:0]  r_p_rc;
    logic signed [48:0]  r_p_rss;
    logic signed [48:0]  r_p_rsc;
    logic                r_out_valid;
    t_vertex             r_out;

    logic [24:0]         w_lat_prod;
    logic [24:0]         w_lon_prod;
    logic [15:0]         w_phase_sel;
    logic [31:0]         w_rom_prod;
    logic [RomAw-1:0]    w_rom_addr;
    logic signed [15:0]  w_rom_data;
    logic signed [16:0]  w_rad;
    logic signed [49:0]  w_half;
    logic signed [49:0]  w_px;
    logic signed [49:0]  w_py;
    logic signed [49:0]  w_pz;
    logic signed [49:0]  w_nx;
    logic signed [49:0]  w_ny;
    logic                w_slot_free;

    assign w_lat_prod = i_job.lat * i_cfg.latitude_step;
    assign w_lon_prod = i_job.slice * i_cfg.longitude_step;

    always_comb begin
        unique case (r_state)
            ST_RD0:  w_phase_sel = r_lat_phase;
            ST_RD1:  w_phase_sel = r_lat_phase + 16'd16384;
            ST_RD2:  w_phase_sel = r_lon_phase;
            ST_RD3:  w_phase_sel = r_lon_phase + 16'd16384;
            default: w_phase_sel = '0;
        endcase
    end

    assign w_rom_prod = 32'(w_phase_sel) * 32'(SINE_ROM_DEPTH);
    assign w_rom_addr = w_rom_prod[RomAw+15:16];

    cmvg_sine_rom #(
        .DEPTH (SINE_ROM_DEPTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_rom_data)
    );

    assign w_rad  = $signed({1'b0, i_cfg.sphere_radius});
    assign w_half = $signed({35'd0, i_cfg.body_length[15:1]});
    assign w_px   = round_shr(50'(r_p_rss), 30);
    assign w_py   = round_shr(50'(r_p_rsc), 30);
    assign w_pz   = round_shr(50'(r_p_rc), 15) + (r_job.neg_off ? -w_half : w_half);
    assign w_nx   = round_shr(50'(r_p_ss), 15);
    assign w_ny   = round_shr(50'(r_p_sc), 15);

    assign w_slot_free = !r_out_valid || i_m_tready;
    assign o_pop       = (r_state == ST_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == ST_OUT) && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_job       <= i_job;
                        r_lat_phase <= w_lat_prod[15:0];
                        r_lon_phase <= w_lon_prod[15:0];
                        r_state     <= ST_RD0;
                    end
                end
                ST_RD0: begin
                    r_state <= ST_RD1;
                end
                ST_RD1: begin
                    r_sl    <= w_rom_data;
                    r_state <= ST_RD2;
                end
                ST_RD2: begin
                    r_cl    <= w_rom_data;
                    r_state <= ST_RD3;
                end
                ST_RD3: begin
                    r_sn    <= w_rom_data;
                    r_state <= ST_RDW;
                end
                ST_RDW: begin
                    r_cn    <= w_rom_data;
                    r_state <= ST_MUL1;
                end
                ST_MUL1: begin
                    r_p_ss  <= r_sl * r_sn;
                    r_p_sc  <= r_sl * r_cn;
                    r_p_rc  <= w_rad * r_cl;
                    r_state <= ST_MUL2;
                end
                ST_MUL2: begin
                    r_p_rss <= w_rad * r_p_ss;
                    r_p_rsc <= w_rad * r_p_sc;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_slot_free) begin
                        r_out.pos_x        <= w_px[16:0];
                        r_out.pos_y        <= w_py[16:0];
                        r_out.pos_z        <= w_pz[17:0];
                        r_out.normal_x     <= w_nx[15:0];
                        r_out.normal_y     <= w_ny[15:0];
                        r_out.normal_z     <= r_cl;
                        r_out.strip_number <= r_job.strip;
                        r_out.strip_end    <= r_job.strip_end;
                        r_out.mesh_end     <= r_job.mesh_end;
                        r_state            <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_vertex   = r_out;

endmodule

### src/capsule_mesh_vertex_generator_top.sv
// ----------------------------------------------------------------------------
// capsule_mesh_vertex_generator_top
// streams the vertices of a tessellated capsule, one vertex per input word
// ----------------------------------------------------------------------------
// Each input word yields one vertex word: bit 0 of the input set restarts the
// mesh at its first vertex, clear advances one vertex. Vertices come in quad
// strip order, upper hemisphere, cylinder, lower hemisphere; tlast marks the
// last vertex of a strip and tuser the last vertex of the mesh. The front end
// takes a word every cycle while its four-entry queue has room; the back end
// works on one vertex at a time and takes the next request only when done;
// each vertex takes four reads in turn of the single-port sine table, two
// multiply stages and a rounding stage. Registers may be written only while
// the block is idle.
module capsule_mesh_vertex_generator_top #(
    parameter int SINE_ROM_DEPTH = cmvg_pkg::DEF_SINE_ROM_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cmvg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cmvg_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // restart
    input  logic [7:0]                      i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, strip_number
    output logic [111:0]                    o_m_tdata,
    // strip_end
    output logic                            o_m_tlast,
    // mesh_end
    output logic                            o_m_tuser
);
    import cmvg_pkg::*;

    t_cfg    r_cfg;
    logic    w_push;
    logic    w_pop;
    logic    w_full;
    logic    w_empty;
    t_job    w_job_in;
    t_job    w_job_out;
    t_vertex w_vertex;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sphere_radius  <= RST_SPHERE_RADIUS;
            r_cfg.body_length    <= RST_BODY_LENGTH;
            r_cfg.stack_count    <= RST_STACK_COUNT;
            r_cfg.slice_count    <= RST_SLICE_COUNT;
            r_cfg.latitude_step  <= RST_LATITUDE_STEP;
            r_cfg.longitude_step <= RST_LONGITUDE_STEP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SPHERE_RADIUS:  r_cfg.sphere_radius  <= i_cfg_wdata;
                CFG_BODY_LENGTH:    r_cfg.body_length    <= i_cfg_wdata;
                CFG_STACK_COUNT:    r_cfg.stack_count    <= i_cfg_wdata[CNT_W-1:0];
                CFG_SLICE_COUNT:    r_cfg.slice_count    <= i_cfg_wdata[CNT_W-1:0];
                CFG_LATITUDE_STEP:  r_cfg.latitude_step  <= i_cfg_wdata;
                CFG_LONGITUDE_STEP: r_cfg.longitude_step <= i_cfg_wdata;
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    cmvg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_restart  (i_s_tdata[0]),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_job      (w_job_in)
    );

    cmvg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_rdata (w_job_out),
        .o_empty (w_empty)
    );

    cmvg_back #(
        .SINE_ROM_DEPTH (SINE_ROM_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_empty    (w_empty),
        .i_job      (w_job_out),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_vertex   (w_vertex)
    );

    assign o_m_tdata = {3'd0, w_vertex.strip_number, w_vertex.normal_z, w_vertex.normal_y,
                        w_vertex.normal_x, w_vertex.pos_z, w_vertex.pos_y, w_vertex.pos_x};
    assign o_m_tlast = w_vertex.strip_end;
    assign o_m_tuser = w_vertex.mesh_end;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("queue read while empty");

    a_mesh_end_on_strip_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> o_m_tlast)
        else $error("mesh end without strip end");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

### tb/capsule_mesh_vertex_generator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capsule_mesh_vertex_generator_top_tb
// Self-checking bench for the capsule vertex streamer. A local predictor
// walks the same strips, slices and vertex pairs and computes the expected
// vertex for every accepted input word. Each output word is compared field
// by field with the oldest expected vertex. Directed words cover the reset
// state, register extremes, count clamping, zero radius and counters left
// past shrunken limits. Random phases with new register settings follow,
// with bursty input, a patterned output stall and one long output hold-off.
// ----------------------------------------------------------------------------
module capsule_mesh_vertex_generator_top_tb;
    import cmvg_pkg::*;

    localparam int ROM_DEPTH      = DEF_SINE_ROM_DEPTH;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 30;

    typedef enum {RX_STEADY, RX_COIN, RX_PERIODIC, RX_MOSTLY} t_rx_mode;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [111:0]         m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;

    // predictor copy of the registers and walk counters
    int unsigned reg_radius   = RST_SPHERE_RADIUS;
    int unsigned reg_length   = RST_BODY_LENGTH;
    int unsigned reg_stacks   = RST_STACK_COUNT;
    int unsigned reg_slices   = RST_SLICE_COUNT;
    int unsigned reg_lat_step = RST_LATITUDE_STEP;
    int unsigned reg_lon_step = RST_LONGITUDE_STEP;
    int unsigned walk_strip   = 0;
    int unsigned walk_slice   = 0;
    int unsigned walk_pair    = 0;

    t_vertex vertex_queue[$];
    int      err_count  = 0;
    int      burst_left = 0;
    bit      gapless    = 1'b0;
    bit      hold_req   = 1'b0;

    capsule_mesh_vertex_generator_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast),
        .o_m_tuser   (m_tuser)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic int quarter_sine(input int unsigned x);
        int unsigned     x2;
        int unsigned     t;
        longint unsigned v;
        x2 = (x * x) >> 14;
        t  = 21024 - ((2320 * x2) >> 14);
        t  = 51472 - ((t * x2) >> 14);
        v  = (64'(t) * 64'(x)) >> 14;
        return (v > 32767) ? 32767 : int'(v);
    endfunction

    function automatic int rom_sine(input int unsigned phase);
        int unsigned addr;
        int unsigned a;
        int unsigned quad;
        int unsigned f;
        int          m;
        addr = ((phase & 32'hFFFF) * ROM_DEPTH) >> 16;
        a    = ((addr * 65536) / ROM_DEPTH) & 32'hFFFF;
        quad = a >> 14;
        f    = a & 32'h3FFF;
        m    = quad[0] ? quarter_sine(16384 - f) : quarter_sine(f);
        return quad[1] ? -m : m;
    endfunction

    function automatic longint round_shift(input longint p, input int sh);
        longint m;
        m = (p < 0) ? -p : p;
        m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
        return (p < 0) ? -m : m;
    endfunction

    function automatic t_vertex predict_vertex(input logic restart);
        int unsigned stacks;
        int unsigned slices;
        int unsigned half_s;
        int unsigned lat;
        int unsigned lat_ph;
        int unsigned lon_ph;
        longint      half_len;
        longint      off;
        longint      rad;
        longint      sl;
        longint      cl;
        longint      sn;
        longint      cn;
        logic        s_end;
        logic        m_end;
        t_vertex     v;
        stacks   = (reg_stacks < 2) ? 2 : (reg_stacks > MAX_STACKS) ? MAX_STACKS : reg_stacks;
        slices   = (reg_slices < 3) ? 3 : (reg_slices > MAX_SLICES) ? MAX_SLICES : reg_slices;
        half_s   = stacks / 2;
        half_len = longint'(reg_length >> 1);
        rad      = longint'(reg_radius);
        if (restart) begin
            walk_strip = 0;
            walk_slice = 0;
            walk_pair  = 0;
        end
        if (walk_strip < half_s) begin
            lat = walk_strip + walk_pair;
            off = half_len;
        end else if (walk_strip == half_s) begin
            lat = half_s;
            off = walk_pair ? -half_len : half_len;
        end else begin
            lat = walk_strip - 1 + walk_pair;
            off = -half_len;
        end
        lat_ph = (lat * reg_lat_step) & 32'hFFFF;
        lon_ph = (walk_slice * reg_lon_step) & 32'hFFFF;
        sl = rom_sine(lat_ph);
        cl = rom_sine(lat_ph + 16384);
        sn = rom_sine(lon_ph);
        cn = rom_sine(lon_ph + 16384);
        s_end = (walk_pair != 0) && (walk_slice >= slices);
        m_end = s_end && (walk_strip >= stacks);
        v.pos_x        = 17'(round_shift(rad * sl * sn, 30));
        v.pos_y        = 17'(round_shift(rad * sl * cn, 30));
        v.pos_z        = 18'(round_shift(rad * cl, 15) + off);
        v.normal_x     = 16'(round_shift(sl * sn, 15));
        v.normal_y     = 16'(round_shift(sl * cn, 15));
        v.normal_z     = 16'(cl);
        v.strip_number = 9'(walk_strip);
        v.strip_end    = s_end;
        v.mesh_end     = m_end;
        if (walk_pair == 0) begin
            walk_pair = 1;
        end else begin
            walk_pair = 0;
            if (s_end) begin
                walk_slice = 0;
                walk_strip = m_end ? 0 : walk_strip + 1;
            end else begin
                walk_slice++;
            end
        end
        return v;
    endfunction

    function automatic void check_field(input string name, input longint expv,
                                        input longint actv);
        if (expv != actv) begin
            err_count++;
            $error("%s: expected %0d, got %0d", name, expv, actv);
        end
    endfunction

    task automatic send_word(input logic restart);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (gapless || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'($urandom), restart};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        vertex_queue.push_back(predict_vertex(restart));
    endtask

    task automatic wait_idle(input int settle);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (vertex_queue.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_SPHERE_RADIUS:  reg_radius   = value;
            CFG_BODY_LENGTH:    reg_length   = value;
            CFG_STACK_COUNT:    reg_stacks   = value[CNT_W-1:0];
            CFG_SLICE_COUNT:    reg_slices   = value[CNT_W-1:0];
            CFG_LATITUDE_STEP:  reg_lat_step = value;
            CFG_LONGITUDE_STEP: reg_lon_step = value;
            default: ;
        endcase
    endtask

    task automatic test_reset_state();
        send_word(1'b0);
        send_word(1'b0);
        send_word(1'b1);
    endtask

    task automatic test_extremes();
        wait_idle(SETTLE_CYCLES);
        write_reg(CFG_SPHERE_RADIUS, 16'hFFFF);
        write_reg(CFG_BODY_LENGTH, 16'hFFFF);
        write_reg(CFG_STACK_COUNT, 16'd2);
        write_reg(CFG_SLICE_COUNT, 16'd3);
        write_reg(CFG_LATITUDE_STEP, 16'd32768);
        write_reg(CFG_LONGITUDE_STEP, 16'd21845);
        send_word(1'b1);
        repeat (5) send_word(1'b0);
    endtask

    task automatic test_clamping();
        wait_idle(SETTLE_CYCLES);
        write_reg(CFG_STACK_COUNT, 16'd0);
        write_reg(CFG_SLICE_COUNT, 16'd0);
        send_word(1'b1);
        repeat (3) send_word(1'b0);
        wait_idle(SETTLE_CYCLES);
        write_reg(CFG_STACK_COUNT, 16'd511);
        write_reg(CFG_SLICE_COUNT, 16'd511);
        write_reg(CFG_LATITUDE_STEP, 16'hFFFF);
        write_reg(CFG_LONGITUDE_STEP, 16'hFFFF);
        send_word(1'b1);
        repeat (3) send_word(1'b0);
    endtask

    task automatic test_zero_radius();
        wait_idle(SETTLE_CYCLES);
        write_reg(CFG_SPHERE_RADIUS, 16'd0);
        write_reg(CFG_BODY_LENGTH, 16'd1);
        write_reg(CFG_STACK_COUNT, 16'd4);
        write_reg(CFG_SLICE_COUNT, 16'd4);
        write_reg(CFG_LATITUDE_STEP, 16'd8192);
        write_reg(CFG_LONGITUDE_STEP, 16'd16384);
        send_word(1'b1);
        repeat (3) send_word(1'b0);
    endtask

    task automatic test_shrunk_limits();
        wait_idle(SETTLE_CYCLES);
        write_reg(CFG_SPHERE_RADIUS, 16'd1000);
        write_reg(CFG_STACK_COUNT, 16'd16);
        write_reg(CFG_SLICE_COUNT, 16'd16);
        write_reg(CFG_LATITUDE_STEP, 16'd2048);
        write_reg(CFG_LONGITUDE_STEP, 16'd4096);
        send_word(1'b1);
        repeat (8) send_word(1'b0);
        // slice counter now sits above the new limit
        wait_idle(SETTLE_CYCLES);
        write_reg(CFG_SLICE_COUNT, 16'd3);
        send_word(1'b0);
        send_word(1'b0);
    endtask

    task automatic test_backpressure();
        wait_idle(SETTLE_CYCLES);
        hold_req = 1'b1;
        gapless  = 1'b1;
        repeat (40) send_word(1'b0);
        gapless = 1'b0;
        wait_idle(SETTLE_CYCLES);
    endtask

    task automatic test_random_walk(input int total);
        int          sent;
        int          count;
        int unsigned s_eff;
        int unsigned n_eff;
        bit          write_all;
        logic [15:0] stacks_w;
        logic [15:0] slices_w;
        logic [15:0] lat_w;
        logic [15:0] lon_w;
        logic [15:0] radius_w;
        logic [15:0] length_w;
        sent = 0;
        while (sent < total) begin
            wait_idle(SETTLE_CYCLES);
            case ($urandom_range(0, 7))
                0:       stacks_w = 16'($urandom_range(0, 1));
                1:       stacks_w = 16'($urandom_range(250, 511));
                2:       stacks_w = 16'($urandom);
                default: stacks_w = 16'($urandom_range(2, 6));
            endcase
            case ($urandom_range(0, 7))
                0:       slices_w = 16'($urandom_range(0, 2));
                1:       slices_w = 16'($urandom_range(250, 511));
                2:       slices_w = 16'($urandom);
                default: slices_w = 16'($urandom_range(3, 8));
            endcase
            s_eff = stacks_w[CNT_W-1:0];
            s_eff = (s_eff < 2) ? 2 : (s_eff > MAX_STACKS) ? MAX_STACKS : s_eff;
            n_eff = slices_w[CNT_W-1:0];
            n_eff = (n_eff < 3) ? 3 : (n_eff > MAX_SLICES) ? MAX_SLICES : n_eff;
            case ($urandom_range(0, 7))
                0:       lat_w = 16'd0;
                1:       lat_w = 16'd32768;
                2:       lat_w = 16'($urandom);
                default: lat_w = 16'(32768 / s_eff);
            endcase
            case ($urandom_range(0, 7))
                0:       lon_w = 16'd0;
                1:       lon_w = 16'hFFFF;
                2:       lon_w = 16'($urandom);
                default: lon_w = 16'(65536 / n_eff);
            endcase
            case ($urandom_range(0, 5))
                0:       radius_w = 16'd0;
                1:       radius_w = 16'hFFFF;
                default: radius_w = 16'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0:       length_w = 16'd0;
                1:       length_w = 16'hFFFF;
                2:       length_w = 16'd1;
                default: length_w = 16'($urandom);
            endcase
            write_all = $urandom_range(0, 1);
            if (write_all || $urandom_range(0, 1)) write_reg(CFG_SPHERE_RADIUS, radius_w);
            if (write_all || $urandom_range(0, 1)) write_reg(CFG_BODY_LENGTH, length_w);
            if (write_all || $urandom_range(0, 1)) write_reg(CFG_STACK_COUNT, stacks_w);
            if (write_all || $urandom_range(0, 1)) write_reg(CFG_SLICE_COUNT, slices_w);
            if (write_all || $urandom_range(0, 1)) write_reg(CFG_LATITUDE_STEP, lat_w);
            if (write_all || $urandom_range(0, 1)) write_reg(CFG_LONGITUDE_STEP, lon_w);
            gapless = ($urandom_range(0, 4) == 0);
            count = $urandom_range(30, 90);
            repeat (count) send_word($urandom_range(0, 63) == 0);
            gapless = 1'b0;
            sent += count;
        end
    endtask

    // output side stall pattern, plus the long hold-off on request
    initial begin : rx_pattern
        t_rx_mode mode;
        int       mode_left;
        int       period;
        int       hold_left;
        mode      = RX_STEADY;
        mode_left = 0;
        period    = 2;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                if (hold_left == 0) hold_left = HOLD_CYCLES;
                hold_left--;
                m_tready <= 1'b0;
                if (hold_left == 0) hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 200);
                    period    = $urandom_range(2, 12);
                end
                mode_left--;
                case (mode)
                    RX_STEADY:   m_tready <= 1'b1;
                    RX_COIN:     m_tready <= $urandom_range(0, 1);
                    RX_PERIODIC: m_tready <= ((mode_left % period) == 0);
                    default:     m_tready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    always @(posedge clk) begin
        t_vertex got;
        t_vertex want;
        if (rst_n && m_tvalid && m_tready) begin
            got = t_vertex'({m_tuser, m_tlast, m_tdata[108:0]});
            if (vertex_queue.size() == 0) begin
                err_count++;
                $error("vertex word with no expected vertex");
            end else begin
                want = vertex_queue.pop_front();
                check_field("pos_x", want.pos_x, got.pos_x);
                check_field("pos_y", want.pos_y, got.pos_y);
                check_field("pos_z", want.pos_z, got.pos_z);
                check_field("normal_x", want.normal_x, got.normal_x);
                check_field("normal_y", want.normal_y, got.normal_y);
                check_field("normal_z", want.normal_z, got.normal_z);
                check_field("strip_number", want.strip_number, got.strip_number);
                check_field("strip_end", want.strip_end, got.strip_end);
                check_field("mesh_end", want.mesh_end, got.mesh_end);
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL capsule_mesh_vertex_generator_top");
        $finish;
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_extremes();
        test_clamping();
        test_zero_radius();
        test_shrunk_limits();
        test_backpressure();
        test_random_walk(880);
        wait_idle(60);
        if (err_count == 0) begin
            $display("PASS capsule_mesh_vertex_generator_top");
        end else begin
            $display("FAIL capsule_mesh_vertex_generator_top");
        end
        $finish;
    end

endmodule
